// ===== rtl/bdte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdte_pkg: shared constants and tables for the BCD date/time converter
// Holds the calendar constants and the month and year day-offset tables,
// which are filled in at elaboration.
// ----------------------------------------------------------------------------
package bdte_pkg;

	localparam int EPOCH_YEAR      = 2000;
	localparam int DAYS_TO_EPOCH   = 730425;
	localparam int SECS_PER_DAY    = 86400;
	localparam int SECS_PER_HOUR   = 3600;
	localparam int SECS_PER_MINUTE = 60;

	// Shifted month index 0..22 (March is 0; out-of-range digits reach 22).
	localparam int MONTH_CNT = 23;
	// Year index 0..166 covers the years 1999 through 2165.
	localparam int YEAR_CNT  = 167;

	typedef logic [9:0]  month_days_t [MONTH_CNT];
	typedef logic [16:0] year_days_t  [YEAR_CNT];

	// Days before the first of each shifted month.
	function automatic month_days_t build_month_days();
		month_days_t t;
		for (int m = 0; m < MONTH_CNT; m++) begin
			t[m] = 10'((153 * m + 2) / 5);
		end
		return t;
	endfunction

	// Day count of March 1 of each year, less one and relative to the epoch.
	// Entries are two's complement; the first year comes out negative.
	function automatic year_days_t build_year_days();
		year_days_t t;
		int         y;
		for (int k = 0; k < YEAR_CNT; k++) begin
			y    = EPOCH_YEAR - 1 + k;
			t[k] = 17'(365 * y + y / 4 - y / 100 + y / 400 - DAYS_TO_EPOCH - 1);
		end
		return t;
	endfunction

	localparam month_days_t MONTH_DAYS = build_month_days();
	localparam year_days_t  YEAR_DAYS  = build_year_days();

	// Arithmetic BCD value tens*10 + ones, digits unchecked.
	function automatic logic [7:0] bcd_value(logic [3:0] tens, logic [3:0] ones);
		return 8'({tens, 3'b000}) + 8'({tens, 1'b0}) + 8'(ones);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bcd_datetime_to_epoch_seconds.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_datetime_to_epoch_seconds: RTC BCD registers to seconds since 2000
// Four-stage pipeline that turns six raw BCD clock bytes into a 32-bit
// count of seconds since 2000-01-01 00:00:00.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while in_stall is low and returns its
// result once the request has passed the decode, table, multiply and final
// add stages; the last stage is the output register. Each stage advances
// whenever the stage after it is empty or moving, so bubbles close up and a
// new request is taken while a finished result still waits at the output.
// The input is stalled only when all four stages are full and the output is
// stalled. Each byte is masked to its tens-digit width, digits are not
// checked, and January and February count as months 13 and 14 of the year
// before. Dates before the epoch, including day zero, wrap modulo 2^32 just
// like the rest of the arithmetic. The block keeps no state beyond the
// pipeline, and reset only empties it.
module bcd_datetime_to_epoch_seconds (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  seconds_byte,
	input  wire logic [7:0]  minutes_byte,
	input  wire logic [7:0]  hours_byte,
	input  wire logic [7:0]  day_byte,
	input  wire logic [7:0]  month_byte,
	input  wire logic [7:0]  year_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      elapsed_seconds
);

	// Stage 1: decoded fields and table indexes.
	logic        v_s1;
	logic [6:0]  sec_s1;
	logic [6:0]  min_s1;
	logic [5:0]  hour_s1;
	logic [5:0]  day_s1;
	logic [4:0]  midx_s1;
	logic [7:0]  yidx_s1;

	// Stage 2: signed day count and partial time of day.
	logic        v_s2;
	logic [17:0] days_s2;
	logic [17:0] hsec_s2;
	logic [12:0] msec_s2;

	// Stage 3: day seconds and full time of day.
	logic        v_s3;
	logic [31:0] dsec_s3;
	logic [17:0] tod_s3;

	// Stage 4 is the output register.
	logic        v_s4;
	logic [31:0] total_s4;

	// Each stage loads when it is empty or its contents move on.
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4   = !v_s4 || !out_stall;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// ---------------- Stage 1: BCD decode and month shift ----------------
	logic [6:0] sec_d;
	logic [6:0] min_d;
	logic [5:0] hour_d;
	logic [5:0] day_d;
	logic [4:0] mon_d;
	logic [7:0] year_d;
	logic       early_d;
	logic [4:0] midx_d;
	logic [7:0] yidx_d;

	always_comb begin
		sec_d  = 7'(bdte_pkg::bcd_value({1'b0, seconds_byte[6:4]}, seconds_byte[3:0]));
		min_d  = 7'(bdte_pkg::bcd_value({1'b0, minutes_byte[6:4]}, minutes_byte[3:0]));
		hour_d = 6'(bdte_pkg::bcd_value({2'b00, hours_byte[5:4]}, hours_byte[3:0]));
		day_d  = 6'(bdte_pkg::bcd_value({2'b00, day_byte[5:4]}, day_byte[3:0]));
		mon_d  = 5'(bdte_pkg::bcd_value({3'b000, month_byte[4]}, month_byte[3:0]));
		year_d = bdte_pkg::bcd_value(year_byte[7:4], year_byte[3:0]);
		// Months zero through two belong to the previous year.
		early_d = (mon_d <= 5'd2);
		midx_d  = early_d ? (mon_d + 5'd9) : (mon_d - 5'd3);
		// Index zero is the year 1999.
		yidx_d  = year_d + {7'b0, !early_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			sec_s1  <= sec_d;
			min_s1  <= min_d;
			hour_s1 <= hour_d;
			day_s1  <= day_d;
			midx_s1 <= midx_d;
			yidx_s1 <= yidx_d;
		end
	end

	// ---------------- Stage 2: table lookups and day sum ----------------
	logic [9:0]  mdays_d;
	logic [16:0] ydays_d;
	logic [17:0] days_d;
	logic [17:0] hsec_d;
	logic [12:0] msec_d;

	always_comb begin
		mdays_d = bdte_pkg::MONTH_DAYS[midx_s1];
		ydays_d = bdte_pkg::YEAR_DAYS[yidx_s1];
		days_d  = {12'b0, day_s1} + {8'b0, mdays_d} + {ydays_d[16], ydays_d};
		hsec_d  = 18'(hour_s1) * 18'(bdte_pkg::SECS_PER_HOUR);
		msec_d  = 13'(min_s1) * 13'(bdte_pkg::SECS_PER_MINUTE) + 13'(sec_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			days_s2 <= days_d;
			hsec_s2 <= hsec_d;
			msec_s2 <= msec_d;
		end
	end

	// ---------------- Stage 3: day-to-second multiply ----------------
	logic [31:0] days_ext;
	logic [31:0] dsec_d;
	logic [17:0] tod_d;

	always_comb begin
		// Sign extension makes a negative day count wrap modulo 2^32.
		days_ext = {{14{days_s2[17]}}, days_s2};
		dsec_d   = days_ext * 32'(bdte_pkg::SECS_PER_DAY);
		tod_d    = hsec_s2 + {5'b0, msec_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			dsec_s3 <= dsec_d;
			tod_s3  <= tod_d;
		end
	end

	// ---------------- Stage 4: final add into the output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			total_s4 <= dsec_s3 + {14'b0, tod_s3};
		end
	end

	assign out_valid       = v_s4;
	assign elapsed_seconds = total_s4;

`ifndef SYNTH
	// The input is held off only when every stage is full and the output stalls.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_stall))
		else $error("input stalled while the pipeline has room");

	// An accepted request lands in the first stage.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted request lost at stage 1");

	// A blocked first stage keeps its day and table indexes intact.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s2) |=> (v_s1 && $stable(yidx_s1) && $stable(midx_s1)
			&& $stable(day_s1)))
		else $error("stage 1 request changed while blocked");

	// A request in stage 3 moves to the output whenever the output is free.
	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !v_s4) |=> v_s4)
		else $error("stage 3 request did not reach the output register");
`endif

endmodule
`default_nettype wire
